// File: rtl/rrts_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the round-robin task scheduler.
// Depends on nothing; every other file refers to it by scoped names.
package rrts_pkg;

  // table geometry
  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int COUNT_W   = $clog2(MAX_TASKS + 1);

  // field widths
  localparam int MODE_W   = 2;
  localparam int ENTRY_W  = 64;
  localparam int SLICE_W  = 16;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

  // item modes
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SCHED  = 2'd3;

  // task status codes
  localparam logic [STATUS_W-1:0] ST_READY      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RUNNING    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TERMINATED = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic tick;       // count down the current slice
    logic create;     // add a task if allowed
    logic term;       // mark the current task terminated
    logic walk_init;  // start a ring walk after the current task
    logic walk_step;  // follow one ring link
    logic commit;     // switch to the walk position
    logic result;     // load the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              slice_expired;
    logic              walk_fail;
    logic              walk_hit;
    logic              out_free;
  } stat_t;

  // one result item
  typedef struct packed {
    logic               switched;
    logic [ID_W-1:0]    prev_id;
    logic [ID_W-1:0]    next_id;
    logic [ENTRY_W-1:0] next_entry;
    logic               create_ok;
    logic [ID_W-1:0]    created_id;
    logic [ID_W-1:0]    current_id;
  } result_t;

endpackage

// File: rtl/rrts_in_if.sv
`timescale 1ns / 1ps
// Input channel of the scheduler: valid/ready with mode and entry address.
// Depends on rrts_pkg for field widths.
interface rrts_in_if;
  logic                          valid;
  logic                          ready;
  logic [rrts_pkg::MODE_W-1:0]   mode;
  logic [rrts_pkg::ENTRY_W-1:0]  entry_address;

  modport source (output valid, output mode, output entry_address, input ready);
  modport sink   (input valid, input mode, input entry_address, output ready);
endinterface

// File: rtl/rrts_out_if.sv
`timescale 1ns / 1ps
// Result channel of the scheduler: valid/ready with the switch and create report.
// Depends on rrts_pkg for field widths.
interface rrts_out_if;
  logic                         valid;
  logic                         ready;
  logic                         switched;
  logic [rrts_pkg::ID_W-1:0]    prev_id;
  logic [rrts_pkg::ID_W-1:0]    next_id;
  logic [rrts_pkg::ENTRY_W-1:0] next_entry;
  logic                         create_ok;
  logic [rrts_pkg::ID_W-1:0]    created_id;
  logic [rrts_pkg::ID_W-1:0]    current_id;

  modport source (output valid, output switched, output prev_id, output next_id,
                  output next_entry, output create_ok, output created_id,
                  output current_id, input ready);
  modport sink   (input valid, input switched, input prev_id, input next_id,
                  input next_entry, input create_ok, input created_id,
                  input current_id, output ready);
endinterface

// File: rtl/rrts_dp.sv
`timescale 1ns / 1ps
// Scheduler datapath: task tables, ring walker, slice counters, output register.
// Depends on rrts_pkg; driven by rrts_ctrl through cmd_t and reports stat_t.
module rrts_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rrts_pkg::SLICE_W-1:0]  cfg_wdata,
  input  logic [rrts_pkg::MODE_W-1:0]   in_mode,
  input  logic [rrts_pkg::ENTRY_W-1:0]  in_entry,
  input  rrts_pkg::cmd_t                cmd_i,
  output rrts_pkg::stat_t               stat_o,
  output rrts_pkg::result_t             out_o,
  output logic                          out_valid_o,
  input  logic                          out_ready
);

  // task tables
  logic [rrts_pkg::STATUS_W-1:0] status_r    [rrts_pkg::MAX_TASKS];
  logic [rrts_pkg::SLOT_W-1:0]   link_r      [rrts_pkg::MAX_TASKS];
  logic [rrts_pkg::SLICE_W-1:0]  slice_r     [rrts_pkg::MAX_TASKS];
  logic [rrts_pkg::ENTRY_W-1:0]  entry_tab_r [rrts_pkg::MAX_TASKS];

  // scheduler control state
  logic [rrts_pkg::SLICE_W-1:0]  slice_len_r;
  logic [rrts_pkg::SLOT_W-1:0]   cur_r;
  logic [rrts_pkg::COUNT_W-1:0]  used_r;
  logic                          out_valid_r;

  // per-item working registers
  logic [rrts_pkg::MODE_W-1:0]   mode_r;
  logic [rrts_pkg::ENTRY_W-1:0]  entry_r;
  logic [rrts_pkg::SLOT_W-1:0]   prev_r;
  logic [rrts_pkg::SLOT_W-1:0]   walk_r;
  logic [rrts_pkg::COUNT_W-1:0]  steps_r;
  logic                          sw_r;
  logic                          made_r;
  logic [rrts_pkg::SLOT_W-1:0]   made_id_r;
  logic [rrts_pkg::ENTRY_W-1:0]  next_entry_r;
  rrts_pkg::result_t             out_r;

  logic [rrts_pkg::SLICE_W-1:0]  slice_cur;
  logic                          expired;
  logic                          create_ok;
  logic [rrts_pkg::SLOT_W-1:0]   new_slot;
  logic [rrts_pkg::SLOT_W-1:0]   link_rd;
  logic [rrts_pkg::STATUS_W-1:0] walk_status;
  logic                          walk_fail;
  logic                          walk_hit;

  // decode the current item against the tables
  assign slice_cur   = slice_r[cur_r];
  assign expired     = (slice_cur < rrts_pkg::SLICE_W'(2));
  assign create_ok   = (entry_r != '0) &&
                       (used_r != rrts_pkg::COUNT_W'(rrts_pkg::MAX_TASKS));
  assign new_slot    = used_r[rrts_pkg::SLOT_W-1:0];
  assign link_rd     = link_r[cmd_i.walk_init ? cur_r : walk_r];
  assign walk_status = status_r[walk_r];
  assign walk_fail   = (walk_r == prev_r) ||
                       (steps_r == rrts_pkg::COUNT_W'(rrts_pkg::MAX_TASKS));
  assign walk_hit    = !walk_fail && ((walk_status == rrts_pkg::ST_READY) ||
                                      (walk_status == rrts_pkg::ST_RUNNING));

  assign stat_o.mode          = mode_r;
  assign stat_o.slice_expired = expired;
  assign stat_o.walk_fail     = walk_fail;
  assign stat_o.walk_hit      = walk_hit;
  assign stat_o.out_free      = !out_valid_r || out_ready;

  // update the task tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rrts_pkg::MAX_TASKS; i++) begin
        status_r[i]    <= rrts_pkg::ST_READY;
        link_r[i]      <= '0;
        slice_r[i]     <= rrts_pkg::SLICE_RESET;
        entry_tab_r[i] <= '0;
      end
      status_r[0] <= rrts_pkg::ST_RUNNING;
    end else begin
      if (cmd_i.tick) begin
        slice_r[cur_r] <= expired ? slice_len_r : slice_cur - 1'b1;
      end
      if (cmd_i.create && create_ok) begin
        status_r[new_slot]    <= rrts_pkg::ST_READY;
        slice_r[new_slot]     <= slice_len_r;
        entry_tab_r[new_slot] <= entry_r;
        link_r[new_slot]      <= link_r[0];
        link_r[0]             <= new_slot;
      end
      if (cmd_i.term) begin
        status_r[cur_r] <= rrts_pkg::ST_TERMINATED;
      end
      if (cmd_i.commit) begin
        if (status_r[prev_r] == rrts_pkg::ST_RUNNING) begin
          status_r[prev_r] <= rrts_pkg::ST_READY;
        end
        status_r[walk_r] <= rrts_pkg::ST_RUNNING;
      end
    end
  end

  // hold slice length, current slot, fill count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_len_r <= rrts_pkg::SLICE_RESET;
      cur_r       <= '0;
      used_r      <= rrts_pkg::COUNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        slice_len_r <= cfg_wdata;
      end
      if (cmd_i.create && create_ok) begin
        used_r <= used_r + 1'b1;
      end
      if (cmd_i.commit) begin
        cur_r <= walk_r;
      end
      if (cmd_i.result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // advance the walker and collect the result
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      mode_r       <= in_mode;
      entry_r      <= in_entry;
      sw_r         <= 1'b0;
      made_r       <= 1'b0;
      made_id_r    <= '0;
      next_entry_r <= '0;
    end
    if (cmd_i.create && create_ok) begin
      made_r    <= 1'b1;
      made_id_r <= new_slot;
    end
    if (cmd_i.walk_init) begin
      prev_r  <= cur_r;
      walk_r  <= link_rd;
      steps_r <= '0;
    end
    if (cmd_i.walk_step) begin
      walk_r  <= link_rd;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd_i.commit) begin
      sw_r         <= 1'b1;
      next_entry_r <= entry_tab_r[walk_r];
    end
    if (cmd_i.result) begin
      out_r.switched   <= sw_r;
      out_r.prev_id    <= sw_r ? rrts_pkg::ID_W'(prev_r) : '0;
      out_r.next_id    <= sw_r ? rrts_pkg::ID_W'(walk_r) : '0;
      out_r.next_entry <= next_entry_r;
      out_r.create_ok  <= made_r;
      out_r.created_id <= rrts_pkg::ID_W'(made_id_r);
      out_r.current_id <= rrts_pkg::ID_W'(cur_r);
    end
  end

  assign out_o       = out_r;
  assign out_valid_o = out_valid_r;

`ifndef NO_ASSERTIONS
  a_commit_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.commit |=> (cur_r == $past(walk_r)) && (status_r[cur_r] == rrts_pkg::ST_RUNNING))
    else $error("switched-to task is not current and running");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != '0) && (used_r <= rrts_pkg::COUNT_W'(rrts_pkg::MAX_TASKS)))
    else $error("slot fill count out of range");

  a_create_links: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.create && create_ok) |=>
      (link_r[0] == $past(new_slot)) && (used_r == $past(used_r) + 1'b1))
    else $error("new task not linked after idle slot");

  a_step_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.walk_step |-> (!walk_fail && !walk_hit))
    else $error("ring walk advanced past a decision");
`endif

endmodule

// File: rtl/rrts_ctrl.sv
`timescale 1ns / 1ps
// Scheduler controller: sequences capture, table update, ring walk and result load.
// Depends on rrts_pkg; commands rrts_dp through cmd_t.
module rrts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rrts_pkg::stat_t stat_i,
  output rrts_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WINIT  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // decode next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.mode)
          rrts_pkg::MODE_TICK: begin
            cmd_o.tick = 1'b1;
            state_nxt  = stat_i.slice_expired ? S_WINIT : S_FINISH;
          end
          rrts_pkg::MODE_CREATE: begin
            cmd_o.create = 1'b1;
            state_nxt    = S_FINISH;
          end
          rrts_pkg::MODE_EXIT: begin
            cmd_o.term = 1'b1;
            state_nxt  = S_WINIT;
          end
          rrts_pkg::MODE_SCHED: begin
            state_nxt = S_WINIT;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_WINIT: begin
        cmd_o.walk_init = 1'b1;
        state_nxt       = S_WALK;
      end
      S_WALK: begin
        if (stat_i.walk_fail) begin
          state_nxt = S_FINISH;
        end else if (stat_i.walk_hit) begin
          cmd_o.commit = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.result = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/round_robin_task_scheduler.sv
`timescale 1ns / 1ps
// Round-robin task scheduler, top level: controller plus datapath.
// Items are taken one at a time, only in idle. Ticks that do not expire and creates go from decode
// to finish, which loads the result once the output is free. Schedule, exit and expiring ticks walk
// the ring in between, following one link of the ring table per cycle until it finds a ready or running task or fails.
// Synchronous active-low reset: slot 0 running and self-linked, slice length 10, no result.
module round_robin_task_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rrts_pkg::SLICE_W-1:0]  cfg_wdata,
  rrts_in_if.sink                       in_ch,
  rrts_out_if.source                    out_ch
);

  rrts_pkg::cmd_t    cmd;
  rrts_pkg::stat_t   stat;
  rrts_pkg::result_t res;
  logic              res_valid;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  rrts_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mode     (in_ch.mode),
    .in_entry    (in_ch.entry_address),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (res),
    .out_valid_o (res_valid),
    .out_ready   (out_ch.ready)
  );

  // drive the result channel
  assign out_ch.valid      = res_valid;
  assign out_ch.switched   = res.switched;
  assign out_ch.prev_id    = res.prev_id;
  assign out_ch.next_id    = res.next_id;
  assign out_ch.next_entry = res.next_entry;
  assign out_ch.create_ok  = res.create_ok;
  assign out_ch.created_id = res.created_id;
  assign out_ch.current_id = res.current_id;

endmodule
